// ===== hw/rtl/pwook_pkg.sv =====
// Shared types and constants of the pulse-width on-off-keyed frame transmitter.
// Holds the register map, the register file struct, the phase codes and reset values.
// Depends on nothing.
package pwook_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int DUR_W      = 16;
	localparam int REP_W      = 4;
	localparam int BPP_W      = 7;
	localparam int PKT_IN_W   = 64;
	localparam int S_DATA_W   = 2 * PKT_IN_W;
	localparam int M_DATA_W   = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SHORT_PULSE     = 3'd0,
		REG_LONG_PULSE      = 3'd1,
		REG_START_HIGH      = 3'd2,
		REG_MIDDLE_GAP      = 3'd3,
		REG_END_GAP         = 3'd4,
		REG_REPEAT_COUNT    = 3'd5,
		REG_BITS_PER_PACKET = 3'd6
	} reg_idx_t;

	localparam logic [DUR_W-1:0] RST_SHORT_PULSE     = 16'd319;
	localparam logic [DUR_W-1:0] RST_LONG_PULSE      = 16'd944;
	localparam logic [DUR_W-1:0] RST_START_HIGH      = 16'd4543;
	localparam logic [DUR_W-1:0] RST_MIDDLE_GAP      = 16'd28000;
	localparam logic [DUR_W-1:0] RST_END_GAP         = 16'd17500;
	localparam logic [REP_W-1:0] RST_REPEAT_COUNT    = 4'd4;
	localparam logic [BPP_W-1:0] RST_BITS_PER_PACKET = 7'd33;

	typedef struct packed {
		logic [DUR_W-1:0] short_pulse;
		logic [DUR_W-1:0] long_pulse;
		logic [DUR_W-1:0] start_high;
		logic [DUR_W-1:0] middle_gap;
		logic [DUR_W-1:0] end_gap;
		logic [REP_W-1:0] repeat_count;
		logic [BPP_W-1:0] bits_per_packet;
	} cfg_t;

	typedef enum logic [7:0] {
		PH_IDLE   = 8'b0000_0001,
		PH_START  = 8'b0000_0010,
		PH_A_LOW  = 8'b0000_0100,
		PH_A_HIGH = 8'b0000_1000,
		PH_MIDDLE = 8'b0001_0000,
		PH_B_LOW  = 8'b0010_0000,
		PH_B_HIGH = 8'b0100_0000,
		PH_END    = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic frame_done;
	} result_t;

endpackage

// ===== hw/rtl/pwook_cfg.sv =====
// Configuration register file of the frame transmitter.
// Uses pwook_pkg for the register map and reset values.
module pwook_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pwook_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pwook_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output pwook_pkg::cfg_t                 cfg
);

	pwook_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_pulse     <= pwook_pkg::RST_SHORT_PULSE;
			cfg_q.long_pulse      <= pwook_pkg::RST_LONG_PULSE;
			cfg_q.start_high      <= pwook_pkg::RST_START_HIGH;
			cfg_q.middle_gap      <= pwook_pkg::RST_MIDDLE_GAP;
			cfg_q.end_gap         <= pwook_pkg::RST_END_GAP;
			cfg_q.repeat_count    <= pwook_pkg::RST_REPEAT_COUNT;
			cfg_q.bits_per_packet <= pwook_pkg::RST_BITS_PER_PACKET;
		end else if (cfg_we) begin
			case (cfg_index)
				pwook_pkg::REG_SHORT_PULSE:     cfg_q.short_pulse  <= cfg_wdata;
				pwook_pkg::REG_LONG_PULSE:      cfg_q.long_pulse   <= cfg_wdata;
				pwook_pkg::REG_START_HIGH:      cfg_q.start_high   <= cfg_wdata;
				pwook_pkg::REG_MIDDLE_GAP:      cfg_q.middle_gap   <= cfg_wdata;
				pwook_pkg::REG_END_GAP:         cfg_q.end_gap      <= cfg_wdata;
				pwook_pkg::REG_REPEAT_COUNT: begin
					cfg_q.repeat_count <= cfg_wdata[pwook_pkg::REP_W-1:0];
				end
				pwook_pkg::REG_BITS_PER_PACKET: begin
					cfg_q.bits_per_packet <= cfg_wdata[pwook_pkg::BPP_W-1:0];
				end
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/pwook_seq.sv =====
// Frame sequencer: phase, segment timer, bit and repeat counters, stored packets.
// Computes the next state and the result of one beat. Uses pwook_pkg.
module pwook_seq #(
	parameter int TIMER_BITS      = 16,
	parameter int MAX_PACKET_BITS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pwook_pkg::cfg_t                cfg,
	input  logic                           step,
	input  logic                           action,
	input  logic [pwook_pkg::PKT_IN_W-1:0] packet_a,
	input  logic [pwook_pkg::PKT_IN_W-1:0] packet_b,
	output pwook_pkg::result_t             res
);

	localparam int BIW = (MAX_PACKET_BITS > 1) ? $clog2(MAX_PACKET_BITS) : 1;
	localparam logic [31:0] TMAX = (32'd1 << TIMER_BITS) - 32'd1;
	localparam int BW = pwook_pkg::BPP_W;
	localparam int RW = pwook_pkg::REP_W;

	function automatic logic [TIMER_BITS-1:0] load_time(input logic [pwook_pkg::DUR_W-1:0] d);
		logic [pwook_pkg::DUR_W-1:0] dd;
		dd = (d == '0) ? pwook_pkg::DUR_W'(1) : d;
		if (32'(dd) > TMAX) begin
			return '1;
		end
		return TIMER_BITS'(dd);
	endfunction

	pwook_pkg::phase_t          phase_q, phase_d;
	logic [TIMER_BITS-1:0]      time_q, time_d;
	logic [BIW-1:0]             bit_q, bit_d;
	logic [RW-1:0]              rep_q, rep_d;
	logic [MAX_PACKET_BITS-1:0] pkt_a_q, pkt_a_d, pkt_b_q, pkt_b_d;
	logic                       line_q, line_d;
	logic                       done;
	logic                       pk_go, sec, bitval;
	logic [BW-1:0]              n, nb, pos;
	logic [RW:0]                reps;

	always_comb begin
		n = (cfg.bits_per_packet > BW'(MAX_PACKET_BITS)) ? BW'(MAX_PACKET_BITS)
			: cfg.bits_per_packet;
		reps = (cfg.repeat_count == '0) ? (RW+1)'(1) : {1'b0, cfg.repeat_count};
	end

	always_comb begin
		phase_d = phase_q;
		time_d  = time_q;
		bit_d   = bit_q;
		rep_d   = rep_q;
		pkt_a_d = pkt_a_q;
		pkt_b_d = pkt_b_q;
		line_d  = line_q;
		done    = 1'b0;
		pk_go   = 1'b0;
		sec     = 1'b0;
		nb      = '0;
		pos     = '0;
		bitval  = 1'b0;
		if (action) begin
			if (phase_q == pwook_pkg::PH_IDLE) begin
				pkt_a_d = packet_a[MAX_PACKET_BITS-1:0];
				pkt_b_d = packet_b[MAX_PACKET_BITS-1:0];
				rep_d   = '0;
				bit_d   = '0;
				phase_d = pwook_pkg::PH_START;
				line_d  = 1'b1;
				time_d  = load_time(cfg.start_high);
			end
		end else if (phase_q != pwook_pkg::PH_IDLE) begin
			if (time_q <= TIMER_BITS'(1)) begin
				time_d = '0;
				case (phase_q)
					pwook_pkg::PH_START: begin
						pk_go = 1'b1;
					end
					pwook_pkg::PH_MIDDLE: begin
						pk_go = 1'b1;
						sec   = 1'b1;
					end
					pwook_pkg::PH_A_HIGH: begin
						pk_go = 1'b1;
						nb    = BW'(bit_q) + BW'(1);
					end
					pwook_pkg::PH_B_HIGH: begin
						pk_go = 1'b1;
						sec   = 1'b1;
						nb    = BW'(bit_q) + BW'(1);
					end
					pwook_pkg::PH_A_LOW: begin
						phase_d = pwook_pkg::PH_A_HIGH;
						line_d  = 1'b1;
						time_d  = load_time(cfg.short_pulse);
					end
					pwook_pkg::PH_B_LOW: begin
						phase_d = pwook_pkg::PH_B_HIGH;
						line_d  = 1'b1;
						time_d  = load_time(cfg.short_pulse);
					end
					pwook_pkg::PH_END: begin
						if ({1'b0, rep_q} + (RW+1)'(1) >= reps) begin
							phase_d = pwook_pkg::PH_IDLE;
							line_d  = 1'b0;
							bit_d   = '0;
							rep_d   = '0;
							done    = 1'b1;
						end else begin
							rep_d   = rep_q + RW'(1);
							phase_d = pwook_pkg::PH_START;
							line_d  = 1'b1;
							time_d  = load_time(cfg.start_high);
						end
					end
					default: begin
						phase_d = pwook_pkg::PH_IDLE;
						line_d  = 1'b0;
					end
				endcase
				if (pk_go) begin
					line_d = 1'b0;
					if (nb >= n) begin
						bit_d   = '0;
						phase_d = sec ? pwook_pkg::PH_END : pwook_pkg::PH_MIDDLE;
						time_d  = load_time(sec ? cfg.end_gap : cfg.middle_gap);
					end else begin
						bit_d   = nb[BIW-1:0];
						pos     = n - BW'(1) - nb;
						bitval  = sec ? pkt_b_q[pos[BIW-1:0]] : pkt_a_q[pos[BIW-1:0]];
						phase_d = sec ? pwook_pkg::PH_B_LOW : pwook_pkg::PH_A_LOW;
						time_d  = load_time(bitval ? cfg.long_pulse : cfg.short_pulse);
					end
				end
			end else begin
				time_d = time_q - TIMER_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pwook_pkg::PH_IDLE;
			time_q  <= '0;
			bit_q   <= '0;
			rep_q   <= '0;
			pkt_a_q <= '0;
			pkt_b_q <= '0;
			line_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			time_q  <= time_d;
			bit_q   <= bit_d;
			rep_q   <= rep_d;
			pkt_a_q <= pkt_a_d;
			pkt_b_q <= pkt_b_d;
			line_q  <= line_d;
		end
	end

	always_comb begin
		res.line_level = line_d;
		res.busy_res   = (phase_d != pwook_pkg::PH_IDLE);
		res.frame_done = done;
	end

endmodule

// ===== hw/rtl/pulse_width_ook_frame_transmitter.sv =====
// An accepted input beat goes through the input register, then the sequencer steps it
// into the result register; a low m_tready holds it back. Throughput: one beat per cycle
// while the output is not stalled; the input register and result register each hold one beat.
// Reset (arst_n low) idles the sequencer with the line low, empties both registers and
// loads the configuration registers with their default values.
module pulse_width_ook_frame_transmitter #(
	parameter int TIMER_BITS      = 16,
	parameter int MAX_PACKET_BITS = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [pwook_pkg::S_DATA_W-1:0]   s_tdata,  // packet_a [63:0], packet_b [127:64]
	input  logic                             s_tuser,  // action [0]
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [pwook_pkg::M_DATA_W-1:0]   m_tdata,  // line_level [0], busy_res [1], zero [7:2]
	output logic                             m_tlast,  // frame_done
	input  logic                             cfg_we,
	input  logic [pwook_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pwook_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	pwook_pkg::cfg_t                cfg;
	pwook_pkg::result_t             res, res_q;
	logic                           valid_s1, valid_q;
	logic                           action_s1;
	logic [pwook_pkg::PKT_IN_W-1:0] packet_a_s1, packet_b_s1;
	logic                           out_free, step;

	assign out_free = !valid_q || m_tready;
	assign step     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1   <= s_tuser;
			packet_a_s1 <= s_tdata[pwook_pkg::PKT_IN_W-1:0];
			packet_b_s1 <= s_tdata[pwook_pkg::S_DATA_W-1:pwook_pkg::PKT_IN_W];
		end
	end

	pwook_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pwook_seq #(
		.TIMER_BITS      (TIMER_BITS),
		.MAX_PACKET_BITS (MAX_PACKET_BITS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.step     (step),
		.action   (action_s1),
		.packet_a (packet_a_s1),
		.packet_b (packet_b_s1),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {(pwook_pkg::M_DATA_W-2)'(0), res_q.busy_res, res_q.line_level};
	assign m_tlast  = res_q.frame_done;

endmodule

// ===== hw/rtl/pwook_chk.sv =====
// Port checker of the frame transmitter and its bind to the top level.
// Sees the top-level ports only; depends on pwook_pkg for widths.
module pwook_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [pwook_pkg::M_DATA_W-1:0]   m_tdata,
	input logic                             m_tlast
);

	a_done_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> !m_tdata[1] && !m_tdata[0])
		else $error("frame end beat does not show an idle, low line");

	a_idle_line_low: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[1] |-> !m_tdata[0])
		else $error("line high while idle");

	a_stall_only_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled while the output side can move");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result beat changed while stalled");

endmodule

bind pulse_width_ook_frame_transmitter pwook_chk u_pwook_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
